@@ hdl/circular_deque_defines.svh @@
// Assertion helpers for the circular deque.
// Both macros expect clk and rst_n in scope.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CDQ_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("circular_deque: same-cycle check failed");
// next-cycle implication
`define CDQ_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("circular_deque: next-cycle check failed");
`else
`define CDQ_ASSERT_NOW(lbl, pre, post)
`define CDQ_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ hdl/cdq_pkg.sv @@
package cdq_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 8;
    localparam int DATA_W = 32;
    localparam int LCW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_REAR   = 2'd3;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] occ;
        logic             pop;    // successful pop, read data is the answer
    } result_t;

    // zero acts as one, anything above DEPTH acts as DEPTH
    function automatic logic [CNT_W-1:0] live_cap(input logic [CAP_W-1:0] c);
        logic [LCW-1:0] ce;
        ce = LCW'(c);
        if (ce == '0)
            ce = LCW'(1);
        else if (ce > LCW'(DEPTH))
            ce = LCW'(DEPTH);
        return CNT_W'(ce);
    endfunction

endpackage

@@ hdl/cdq_ram.sv @@
module cdq_ram (
    input  logic                     clk,
    input  cdq_pkg::mem_req_t        mem_req,
    output logic [cdq_pkg::DATA_W-1:0] rdata
);
    import cdq_pkg::*;

    logic [DATA_W-1:0] slot_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
            slot_mem[mem_req.addr] <= mem_req.wdata;
        if (mem_req.re)
            rdata_reg <= slot_mem[mem_req.addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/cdq_ctrl.sv @@
module cdq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]  cfg_wdata,
    input  logic                       req_fire,
    input  logic [1:0]                 cmd,
    input  logic [cdq_pkg::DATA_W-1:0] value,
    output cdq_pkg::mem_req_t          mem_req,
    output cdq_pkg::result_t           result
);
    import cdq_pkg::*;

    logic [CNT_W-1:0]  cap_reg;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] cap_m1;
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;

    assign full   = (count_reg >= cap_reg);
    assign empty  = (count_reg == '0);
    assign cap_m1 = ADDR_W'(cap_reg - CNT_W'(1));

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        we            = 1'b0;
        re            = 1'b0;
        addr          = '0;
        result.status = STATUS_DONE;
        result.pop    = 1'b0;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (full)
                    result.status = STATUS_FULL;
                else
                begin
                    we = 1'b1;
                    if (empty)
                    begin
                        head_next = '0;
                        tail_next = '0;
                        addr      = '0;
                    end
                    else if (cmd == CMD_PUSH_FRONT)
                    begin
                        head_next = (head_reg == '0) ? cap_m1 : head_reg - ADDR_W'(1);
                        addr      = head_next;
                    end
                    else
                    begin
                        tail_next = (tail_reg >= cap_m1) ? '0 : tail_reg + ADDR_W'(1);
                        addr      = tail_next;
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR:
            begin
                if (empty)
                    result.status = STATUS_EMPTY;
                else
                begin
                    re         = 1'b1;
                    result.pop = 1'b1;
                    addr       = (cmd == CMD_POP_FRONT) ? head_reg : tail_reg;
                    if (count_reg == CNT_W'(1))
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        if (cmd == CMD_POP_FRONT)
                            head_next = (head_reg >= cap_m1) ? '0 : head_reg + ADDR_W'(1);
                        else
                            tail_next = (tail_reg == '0) ? cap_m1 : tail_reg - ADDR_W'(1);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                result.status = STATUS_DONE;
            end
        endcase
        result.occ = count_next;
    end

    assign mem_req.we    = we & req_fire;
    assign mem_req.re    = re & req_fire;
    assign mem_req.addr  = addr;
    assign mem_req.wdata = value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= live_cap(CAP_RESET);
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            // new capacity empties the deque
            cap_reg   <= live_cap(cfg_wdata);
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (req_fire)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/circular_deque.sv @@
// Double-ended queue in a circular slot memory of cdq_pkg::DEPTH 32-bit words.
// Each request on the slave stream is one command (tuser: push front, push
// rear, pop front, pop rear); each gives exactly one response on the master
// stream with a status, the popped word (zero unless a pop succeeded) and the
// occupancy after the command. The block takes one command per cycle while
// the response path is not stalled: head, tail and count update at the accept
// edge and the single memory access (write for a push, read for a pop) issues
// in that same cycle. A response passes through the response stage, which waits
// on the registered slot memory read data, and then the output register. These
// two keep requests flowing while a response waits. Writing cfg_wdata
// sets the capacity (zero acts as one, above DEPTH acts as DEPTH) and empties
// the deque; write it only while no command is in flight. There is no clearing
// pass after reset: slots are only ever read after a push wrote them.
`include "circular_deque_defines.svh"

module circular_deque (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: capacity
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // command requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // responses
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] popped, [39:32] occupancy
    output logic [1:0]  m_tuser    // [1:0] status
);
    import cdq_pkg::*;

    cdq_pkg::mem_req_t mem_req;
    cdq_pkg::result_t  result;
    logic [DATA_W-1:0] rdata;

    logic s_fire;
    logic out_free;
    logic advance;

    // response stage: waits on the memory read data
    logic             pend_valid_reg;
    logic [1:0]       pend_status_reg;
    logic [CNT_W-1:0] pend_occ_reg;
    logic             pend_pop_reg;

    // output register
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [DATA_W-1:0] out_popped_reg;
    logic [CNT_W-1:0]  out_occ_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = pend_valid_reg && out_free;
    assign s_tready = !pend_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_fire  (s_fire),
        .cmd       (s_tuser),
        .value     (s_tdata),
        .mem_req   (mem_req),
        .result    (result)
    );

    cdq_ram u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (s_fire)
            pend_valid_reg <= 1'b1;
        else if (advance)
            pend_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            pend_status_reg <= result.status;
            pend_occ_reg    <= result.occ;
            pend_pop_reg    <= result.pop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // read data holds while the response stage stalls: no new read issues
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= pend_status_reg;
            out_popped_reg <= pend_pop_reg ? rdata : '0;
            out_occ_reg    <= pend_occ_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {8'(out_occ_reg), out_popped_reg};

    // no request may land on a stalled response stage
    `CDQ_ASSERT_NOW(a_no_overrun, s_fire, !(pend_valid_reg && !out_free))
    // an accepted request always occupies the response stage next cycle
    `CDQ_ASSERT_NEXT(a_pend_loaded, s_fire, pend_valid_reg)
    // a refused command never reports a popped word
    `CDQ_ASSERT_NOW(a_refused_zero, out_valid_reg && out_status_reg != STATUS_DONE,
                    out_popped_reg == '0)

endmodule
